// File: hw/rtl/edc_pkg.sv
// Shared constants, payload types and the gray conversion for the edge density
// and contrast block. No dependencies; every other file of the block imports it.
`default_nettype none

package edc_pkg;

   localparam int MAX_WIDTH    = 256;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int HEIGHT_LIMIT = 256;
   localparam int ROW_W        = $clog2(HEIGHT_LIMIT);

   localparam int GRAY_W     = 8;
   localparam int DIFF_W     = GRAY_W + 1;
   localparam int CFG_DIM_W  = 9;
   localparam int THR_W      = 17;
   localparam int TOTAL_W    = 17;
   localparam int COUNT_W    = 16;
   localparam int GRAY_SUM_W = GRAY_W + 5;

   localparam int REQ_W = 3 * GRAY_W;
   localparam int RSP_W = 2 * COUNT_W + 3 * GRAY_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_THRESHOLD = 2'd2;

   localparam logic [CFG_DIM_W-1:0] WIDTH_RESET     = 9'd256;
   localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET    = 9'd256;
   localparam logic [THR_W-1:0]     THRESHOLD_RESET = 17'd2601;

   localparam logic [GRAY_W-1:0] GRAY_MAX_VALUE = 8'd255;

   localparam logic [GRAY_SUM_W-1:0] RED_WEIGHT   = 13'd11;
   localparam logic [GRAY_SUM_W-1:0] GREEN_WEIGHT = 13'd16;
   localparam logic [GRAY_SUM_W-1:0] BLUE_WEIGHT  = 13'd5;

   // One pixel after the line buffers, ready for the gradient test
   typedef struct packed {
      logic signed [DIFF_W-1:0] gx;
      logic signed [DIFF_W-1:0] gy;
      logic [GRAY_W-1:0]        gray;
      logic                     interior;
      logic                     frame_end;
   } edc_item_type;

   // Frame geometry after clamping: index of the last column and last row
   typedef struct packed {
      logic [COL_W-1:0] last_col;
      logic [ROW_W-1:0] last_row;
   } edc_geom_type;

   function automatic logic [GRAY_W-1:0] gray_of(
      input logic [GRAY_W-1:0] red,
      input logic [GRAY_W-1:0] green,
      input logic [GRAY_W-1:0] blue
   );
      logic [GRAY_SUM_W-1:0] sum;
      sum = GRAY_SUM_W'(red) * RED_WEIGHT + GRAY_SUM_W'(green) * GREEN_WEIGHT
          + GRAY_SUM_W'(blue) * BLUE_WEIGHT;
      return sum[GRAY_SUM_W-1:5];
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/edge_density_contrast.sv
// Edge density and contrast statistics over one frame of RGB pixels.
// Top level: register port, front end, item queue and statistics back end.
//
// Usage:
//   req_*  carries one RGB pixel per beat in raster order. The block counts
//          interior pixels whose squared central-difference gradient reaches
//          edge_threshold_sq and tracks the gray minimum and maximum.
//   rsp_*  carries one beat per frame, after the frame's last pixel: edge
//          count, interior pixel count, min, max and range of gray.
//   csr_*  writes frame_width (0), frame_height (1) and edge_threshold_sq (2);
//          write only while no frame is in progress. Other indexes are ignored.
// Throughput is one pixel per clock; each line buffer takes one read and one
// write per pixel. The last pixel beat passes the front-end register stage and
// the item queue before the result register. When rsp_tready is low, the
// result holds, pixels keep flowing into a four-entry queue and req_tready
// drops once it is full. Reset restores the register defaults (256 x 256,
// threshold 2601) and starts a new frame; the line buffers need no clearing,
// as rows two and beyond only read entries written earlier in the same frame.
`default_nettype none

module edge_density_contrast (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [edc_pkg::REQ_W-1:0]      req_tdata,   // red, green, blue
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // edge_count, interior_pixels, min_gray, max_gray, gray_range
   output logic [edc_pkg::RSP_W-1:0]      rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [edc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [edc_pkg::CSR_DATA_W-1:0] csr_data
);
   import edc_pkg::*;

   logic [CFG_DIM_W-1:0] width_ff, width_in;
   logic [CFG_DIM_W-1:0] height_ff, height_in;
   logic [THR_W-1:0]     thr_ff, thr_in;

   logic          push;
   edc_item_type  push_item;
   edc_item_type  head;
   logic          pop;
   logic          empty;
   logic [QCNT_W-1:0] fill;
   edc_geom_type  geom;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      thr_in    = thr_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               width_in = csr_data[CFG_DIM_W-1:0];
            end
            CSR_FRAME_HEIGHT: begin
               height_in = csr_data[CFG_DIM_W-1:0];
            end
            CSR_EDGE_THRESHOLD: begin
               thr_in = csr_data[THR_W-1:0];
            end
            default: begin
               width_in = width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         thr_ff    <= THRESHOLD_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         thr_ff    <= thr_in;
      end
   end

   edc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cfg_width  (width_ff),
      .cfg_height (height_ff),
      .queue_fill (fill),
      .push       (push),
      .push_item  (push_item),
      .geom       (geom)
   );

   edc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .empty     (empty),
      .fill      (fill)
   );

   edc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (empty),
      .head        (head),
      .queue_pop   (pop),
      .threshold   (thr_ff),
      .geom        (geom),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: hw/rtl/edc_queue.sv
// Short item queue between the pixel front end and the statistics back end.
// Depends on edc_pkg for the item type and depth.
`default_nettype none

module edc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  edc_pkg::edc_item_type push_item,
   input  logic                 pop,
   output edc_pkg::edc_item_type head,
   output logic                 empty,
   output logic [edc_pkg::QCNT_W-1:0] fill
);
   import edc_pkg::*;

   edc_item_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head  = slot_ff[rd_ptr_ff];
   assign empty = (fill_ff == '0);
   assign fill  = fill_ff;

endmodule

`default_nettype wire

// File: hw/rtl/edc_front.sv
// Pixel front end: accepts pixels, converts to gray, tracks the raster position,
// runs the two line buffers and pushes central differences into the queue.
// Depends on edc_pkg.
`default_nettype none

module edc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [edc_pkg::REQ_W-1:0]     req_tdata,
   input  logic [edc_pkg::CFG_DIM_W-1:0] cfg_width,
   input  logic [edc_pkg::CFG_DIM_W-1:0] cfg_height,
   input  logic [edc_pkg::QCNT_W-1:0]    queue_fill,
   output logic                          push,
   output edc_pkg::edc_item_type         push_item,
   output edc_pkg::edc_geom_type         geom
);
   import edc_pkg::*;

   logic [GRAY_W-1:0] mid_mem  [MAX_WIDTH];
   logic [GRAY_W-1:0] prev_mem [MAX_WIDTH];

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              a_valid_ff, a_valid_in;

   logic [GRAY_W-1:0] a_gray_ff;
   logic [COL_W-1:0]  a_col_ff;
   logic              a_interior_ff;
   logic              a_frame_end_ff;
   logic [GRAY_W-1:0] rd_mid_ff;
   logic [GRAY_W-1:0] rd_prev_ff;

   logic [GRAY_W-1:0] mid1_ff;
   logic [GRAY_W-1:0] mid2_ff;
   logic [GRAY_W-1:0] prev1_ff;
   logic [GRAY_W-1:0] cur1_ff;

   logic accept;
   logic row_end;
   logic frame_end;
   logic interior;

   // Clamp the geometry to the supported range
   always_comb begin
      if (cfg_width < CFG_DIM_W'(3)) begin
         geom.last_col = COL_W'(2);
      end else if (cfg_width > CFG_DIM_W'(MAX_WIDTH)) begin
         geom.last_col = COL_W'(MAX_WIDTH - 1);
      end else begin
         geom.last_col = COL_W'(cfg_width - CFG_DIM_W'(1));
      end
      if (cfg_height < CFG_DIM_W'(3)) begin
         geom.last_row = ROW_W'(2);
      end else if (cfg_height > CFG_DIM_W'(HEIGHT_LIMIT)) begin
         geom.last_row = ROW_W'(HEIGHT_LIMIT - 1);
      end else begin
         geom.last_row = ROW_W'(cfg_height - CFG_DIM_W'(1));
      end
   end

   // Take a beat only if the queue has room for it and the one still in flight
   assign req_tready = ({1'b0, queue_fill} + (QCNT_W + 1)'(a_valid_ff))
                       < (QCNT_W + 1)'(QUEUE_DEPTH);
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      row_end    = (col_ff >= geom.last_col);
      frame_end  = row_end && (row_ff >= geom.last_row);
      interior   = (col_ff >= COL_W'(2)) && (row_ff >= ROW_W'(2));
      a_valid_in = accept;
      col_in     = col_ff;
      row_in     = row_ff;
      if (accept) begin
         if (frame_end) begin
            col_in = '0;
            row_in = '0;
         end else if (row_end) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         a_valid_ff <= a_valid_in;
      end
   end

   // Read the line buffers at the accepted column; consecutive beats never
   // share a column, so the write-back in the next cycle cannot collide
   always_ff @(posedge clock) begin
      if (accept) begin
         a_gray_ff      <= gray_of(req_tdata[GRAY_W-1:0], req_tdata[2*GRAY_W-1:GRAY_W],
                                   req_tdata[3*GRAY_W-1:2*GRAY_W]);
         a_col_ff       <= col_ff;
         a_interior_ff  <= interior;
         a_frame_end_ff <= frame_end;
         rd_mid_ff      <= mid_mem[col_ff];
         rd_prev_ff     <= prev_mem[col_ff];
      end
   end

   // Shift the rows down and advance the column taps
   always_ff @(posedge clock) begin
      if (a_valid_ff) begin
         mid_mem[a_col_ff]  <= a_gray_ff;
         prev_mem[a_col_ff] <= rd_mid_ff;
         mid2_ff            <= mid1_ff;
         mid1_ff            <= rd_mid_ff;
         prev1_ff           <= rd_prev_ff;
         cur1_ff            <= a_gray_ff;
      end
   end

   assign push = a_valid_ff;

   always_comb begin
      push_item.gx        = $signed({1'b0, rd_mid_ff}) - $signed({1'b0, mid2_ff});
      push_item.gy        = $signed({1'b0, cur1_ff}) - $signed({1'b0, prev1_ff});
      push_item.gray      = a_gray_ff;
      push_item.interior  = a_interior_ff;
      push_item.frame_end = a_frame_end_ff;
   end

endmodule

`default_nettype wire

// File: hw/rtl/edc_back.sv
// Statistics back end: gradient threshold test, edge count, gray min and max,
// and the result register on the frame's last pixel. Depends on edc_pkg.
`default_nettype none

module edc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      queue_empty,
   input  edc_pkg::edc_item_type     head,
   output logic                      queue_pop,
   input  logic [edc_pkg::THR_W-1:0] threshold,
   input  edc_pkg::edc_geom_type     geom,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [edc_pkg::RSP_W-1:0] rsp_tdata
);
   import edc_pkg::*;

   logic [TOTAL_W-1:0] edge_ff, edge_in;
   logic [GRAY_W-1:0]  min_ff, min_in;
   logic [GRAY_W-1:0]  max_ff, max_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff;
   logic [COUNT_W-1:0] area_ff, area_in;

   logic [COL_W+ROW_W-1:0] area_full;
   logic signed [2*DIFF_W-1:0] sq_x;
   logic signed [2*DIFF_W-1:0] sq_y;
   logic [THR_W-1:0]   mag;
   logic               is_edge;
   logic [TOTAL_W-1:0] edge_next;
   logic [GRAY_W-1:0]  min_next;
   logic [GRAY_W-1:0]  max_next;

   always_comb begin
      area_full = (COL_W + ROW_W)'(geom.last_col - COL_W'(1))
                * (COL_W + ROW_W)'(geom.last_row - ROW_W'(1));
      area_in   = COUNT_W'(area_full);
   end

   // Drain the queue whenever the result register is free or being taken
   assign queue_pop = !queue_empty && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      sq_x      = head.gx * head.gx;
      sq_y      = head.gy * head.gy;
      mag       = {1'b0, sq_x[2*GRAY_W-1:0]} + {1'b0, sq_y[2*GRAY_W-1:0]};
      is_edge   = head.interior && (mag >= threshold);
      edge_next = edge_ff + TOTAL_W'(is_edge);
      min_next  = (head.gray < min_ff) ? head.gray : min_ff;
      max_next  = (head.gray > max_ff) ? head.gray : max_ff;

      edge_in = edge_ff;
      min_in  = min_ff;
      max_in  = max_ff;
      if (queue_pop) begin
         if (head.frame_end) begin
            edge_in = '0;
            min_in  = GRAY_MAX_VALUE;
            max_in  = '0;
         end else begin
            edge_in = edge_next;
            min_in  = min_next;
            max_in  = max_next;
         end
      end

      if (queue_pop && head.frame_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff      <= '0;
         min_ff       <= GRAY_MAX_VALUE;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         edge_ff      <= edge_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      area_ff <= area_in;
      if (queue_pop && head.frame_end) begin
         rsp_data_ff <= {max_next - min_next, max_next, min_next, area_ff,
                         edge_next[COUNT_W-1:0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// File: bench/edge_density_contrast_tb.sv
// Testbench for edge_density_contrast: streams RGB frames in raster order,
// predicts each frame's edge count and gray statistics, and checks every result beat.
// Depends on edc_pkg and the edge_density_contrast RTL.
`timescale 1ns / 1ps

module edge_density_contrast_tb;
   import edc_pkg::*;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   // declared from the top bit down, so edge_count sits in the lowest bits
   typedef struct packed {
      logic [7:0]  gray_range;
      logic [7:0]  max_gray;
      logic [7:0]  min_gray;
      logic [15:0] interior_pixels;
      logic [15:0] edge_count;
   } frame_stats_type;

   typedef struct packed {
      pixel_type       px;
      logic            typed;
      frame_stats_type want;
   } directed_row_type;

   typedef enum {PIX_NOISE, PIX_BINARY, PIX_SMOOTH} pixel_style_type;
   typedef enum {RSP_ALWAYS, RSP_COIN, RSP_EVERY_FIFTH, RSP_MOSTLY} rsp_pattern_type;

   localparam frame_stats_type NO_STATS = '0;
   localparam int DIR_ROWS = 27;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_PIXELS = 500;
   localparam int RANDOM_FRAMES = 20;
   localparam int MAX_PRINTS = 40;

   // Three 3x3 frames at the reset threshold. First: one white pixel right of
   // center plus single-channel corners. Second: a gray of 51 above center,
   // which lands exactly on the threshold with a negative difference. Third:
   // a gray of 50, just under it.
   localparam directed_row_type DIR_TAB [DIR_ROWS] = '{
      '{24'h0000FF, 1'b0, NO_STATS},
      '{24'h000000, 1'b0, NO_STATS},
      '{24'h00FF00, 1'b0, NO_STATS},
      '{24'h000000, 1'b0, NO_STATS},
      '{24'h000000, 1'b0, NO_STATS},
      '{24'hFFFFFF, 1'b0, NO_STATS},
      '{24'hFF0000, 1'b0, NO_STATS},
      '{24'h000000, 1'b0, NO_STATS},
      '{24'h000000, 1'b1, '{8'd255, 8'd255, 8'd0, 16'd1, 16'd1}},
      '{24'h000000, 1'b0, NO_STATS},
      '{24'h006600, 1'b0, NO_STATS},
      '{24'h000000, 1'b0, NO_STATS},
      '{24'h000000, 1'b0, NO_STATS},
      '{24'h000000, 1'b0, NO_STATS},
      '{24'h000000, 1'b0, NO_STATS},
      '{24'h000000, 1'b0, NO_STATS},
      '{24'h000000, 1'b0, NO_STATS},
      '{24'h000000, 1'b1, '{8'd51, 8'd51, 8'd0, 16'd1, 16'd1}},
      '{24'h000000, 1'b0, NO_STATS},
      '{24'h000000, 1'b0, NO_STATS},
      '{24'h000000, 1'b0, NO_STATS},
      '{24'h000000, 1'b0, NO_STATS},
      '{24'h000000, 1'b0, NO_STATS},
      '{24'h006400, 1'b0, NO_STATS},
      '{24'h000000, 1'b0, NO_STATS},
      '{24'h000000, 1'b0, NO_STATS},
      '{24'h000000, 1'b1, '{8'd50, 8'd50, 8'd0, 16'd1, 16'd0}}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;   // red, green, blue
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   // edge_count, interior_pixels, min_gray, max_gray, gray_range
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   edge_density_contrast dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // Shadow of the block: registers, line buffers, position, taps, statistics
   logic [8:0]   cfg_width = 9'd256;
   logic [8:0]   cfg_height = 9'd256;
   logic [16:0]  cfg_threshold = 17'd2601;
   logic [7:0]   line_prev [MAX_WIDTH];
   logic [7:0]   line_mid [MAX_WIDTH];
   int unsigned  col_at = 0;
   int unsigned  row_at = 0;
   logic [16:0]  edges_so_far = '0;
   logic [7:0]   low_gray = 8'd255;
   logic [7:0]   high_gray = 8'd0;
   logic [7:0]   tap_mid1 = '0;
   logic [7:0]   tap_mid2 = '0;
   logic [7:0]   tap_prev1 = '0;
   logic [7:0]   tap_cur1 = '0;

   frame_stats_type stats_due [$];

   int mismatches = 0;
   int pixels_sent = 0;
   int results_checked = 0;
   int csr_writes = 0;
   int holds_asked = 0;
   int burst_left = 0;
   bit steady = 1'b0;

   function automatic int cols_in_use();
      return (cfg_width < 9'd3) ? 3 : ((cfg_width > 9'd256) ? 256 : int'(cfg_width));
   endfunction

   function automatic int rows_in_use();
      return (cfg_height < 9'd3) ? 3 : ((cfg_height > 9'd256) ? 256 : int'(cfg_height));
   endfunction

   // Advance the shadow by one pixel; flag the frame's last pixel and its statistics
   task automatic track_pixel(input pixel_type px, output bit frame_done,
                              output frame_stats_type s);
      int w, h, gray, gx, gy, mag;
      logic [7:0] m, p;
      w = cols_in_use();
      h = rows_in_use();
      gray = (int'(px.red) * 11 + int'(px.green) * 16 + int'(px.blue) * 5) >> 5;
      m = line_mid[col_at];
      p = line_prev[col_at];
      if (col_at >= 2 && row_at >= 2) begin
         gx = int'(m) - int'(tap_mid2);
         gy = int'(tap_cur1) - int'(tap_prev1);
         mag = gx * gx + gy * gy;
         if (mag >= int'(cfg_threshold))
            edges_so_far = edges_so_far + 17'd1;
      end
      if (gray < int'(low_gray))
         low_gray = 8'(gray);
      if (gray > int'(high_gray))
         high_gray = 8'(gray);
      tap_mid2 = tap_mid1;
      tap_mid1 = m;
      tap_prev1 = p;
      tap_cur1 = 8'(gray);
      line_prev[col_at] = m;
      line_mid[col_at] = 8'(gray);
      frame_done = (col_at >= w - 1) && (row_at >= h - 1);
      s = NO_STATS;
      if (frame_done) begin
         s.edge_count = edges_so_far[15:0];
         s.interior_pixels = 16'((w - 2) * (h - 2));
         s.min_gray = low_gray;
         s.max_gray = high_gray;
         s.gray_range = high_gray - low_gray;
         edges_so_far = '0;
         low_gray = 8'd255;
         high_gray = 8'd0;
         col_at = 0;
         row_at = 0;
      end else if (col_at >= w - 1) begin
         col_at = 0;
         row_at++;
      end else begin
         col_at++;
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < MAX_PRINTS)
         $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   task automatic check_field(input string what, input int got, input int want);
      if (got != want)
         report_mismatch(what, got, want);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_FRAME_WIDTH:    cfg_width = val[8:0];
         CSR_FRAME_HEIGHT:   cfg_height = val[8:0];
         CSR_EDGE_THRESHOLD: cfg_threshold = val[16:0];
         default: ;
      endcase
      csr_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // One pixel beat; bursts of random length with random gaps unless steady
   task automatic send_pixel(input pixel_type px, input bit typed, input frame_stats_type want);
      int gap;
      bit done;
      frame_stats_type s;
      if (!steady && burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(0, 7);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pixels_sent++;
      track_pixel(px, done, s);
      if (done)
         stats_due.insert(stats_due.size(), typed ? want : s);
   endtask

   task automatic send_frame(input pixel_style_type style);
      int n;
      int level;
      pixel_type px;
      n = cols_in_use() * rows_in_use();
      level = $urandom_range(0, 255);
      for (int i = 0; i < n; i++) begin
         case (style)
            PIX_BINARY: px = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
            PIX_SMOOTH: begin
               if ($urandom_range(0, 15) == 0)
                  level = $urandom_range(0, 255);
               else
                  level = level + $urandom_range(0, 8) - 4;
               if (level < 0) level = 0;
               if (level > 255) level = 255;
               px.red = 8'(level);
               px.green = 8'(level ^ $urandom_range(0, 3));
               px.blue = 8'(level ^ $urandom_range(0, 3));
            end
            default: px = 24'($urandom);
         endcase
         send_pixel(px, 1'b0, NO_STATS);
      end
   endtask

   // Hold off until every due result is in and the pipeline has emptied
   task automatic settle();
      while (stats_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [CSR_DATA_W-1:0] wdata, input logic [CSR_DATA_W-1:0] hdata,
                            input logic [CSR_DATA_W-1:0] thr, input int frames,
                            input bit no_gaps, input bit long_hold);
      settle();
      write_reg(CSR_FRAME_WIDTH, wdata);
      write_reg(CSR_FRAME_HEIGHT, hdata);
      write_reg(CSR_EDGE_THRESHOLD, thr);
      steady = no_gaps;
      if (long_hold)
         holds_asked++;
      repeat (frames) send_frame(pixel_style_type'($urandom_range(0, 2)));
      req_tvalid <= 1'b0;
      steady = 1'b0;
   endtask

   // Result side: stall patterns of its own, plus long holds on request
   initial begin : rsp_side
      int holds_done;
      int span;
      int tick;
      rsp_pattern_type mode;
      holds_done = 0;
      tick = 0;
      forever begin
         mode = rsp_pattern_type'($urandom_range(0, 3));
         span = $urandom_range(10, 120);
         repeat (span) begin
            @(posedge clock);
            tick++;
            if (holds_done != holds_asked) begin
               rsp_tready <= 1'b0;
               repeat (LONG_HOLD_CYCLES) @(posedge clock);
               holds_done++;
            end else begin
               case (mode)
                  RSP_ALWAYS:      rsp_tready <= 1'b1;
                  RSP_COIN:        rsp_tready <= 1'($urandom_range(0, 1));
                  RSP_EVERY_FIFTH: rsp_tready <= (tick % 5 == 0);
                  default:         rsp_tready <= ($urandom_range(0, 3) != 0);
               endcase
            end
         end
      end
   end

   always @(posedge clock) begin : result_check
      frame_stats_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (stats_due.size() == 0) begin
            report_mismatch("result beat with nothing due, edge_count", int'(got.edge_count), -1);
         end else begin
            want = stats_due.pop_front();
            check_field("edge_count", int'(got.edge_count), int'(want.edge_count));
            check_field("interior_pixels", int'(got.interior_pixels),
                        int'(want.interior_pixels));
            check_field("min_gray", int'(got.min_gray), int'(want.min_gray));
            check_field("max_gray", int'(got.max_gray), int'(want.max_gray));
            check_field("gray_range", int'(got.gray_range), int'(want.gray_range));
            results_checked++;
         end
      end
   end

   initial begin : stimulus
      int phase_no;
      int random_start;
      int frames_start;
      int frames;
      bit long_hold;
      logic [CSR_DATA_W-1:0] wdata, hdata, thr;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         line_prev[i] = '0;
         line_mid[i] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed frames keep the reset threshold
      settle();
      write_reg(CSR_FRAME_WIDTH, 17'd3);
      write_reg(CSR_FRAME_HEIGHT, 17'd3);
      foreach (DIR_TAB[i])
         send_pixel(DIR_TAB[i].px, DIR_TAB[i].typed, DIR_TAB[i].want);
      req_tvalid <= 1'b0;

      phase_no = 0;
      random_start = pixels_sent;
      frames_start = results_checked + stats_due.size();
      while (pixels_sent - random_start < RANDOM_PIXELS ||
             results_checked + stats_due.size() - frames_start < RANDOM_FRAMES) begin
         wdata = ($urandom_range(0, 9) == 0) ? CSR_DATA_W'($urandom_range(0, 2))
                                             : CSR_DATA_W'($urandom_range(3, 6));
         hdata = ($urandom_range(0, 9) == 0) ? CSR_DATA_W'($urandom_range(0, 2))
                                             : CSR_DATA_W'($urandom_range(3, 5));
         // junk above the 9-bit field must be dropped
         if ($urandom_range(0, 3) == 0) begin
            wdata[16:9] = 8'($urandom);
            hdata[16:9] = 8'($urandom);
         end
         case ($urandom_range(0, 5))
            0: thr = 17'd0;
            1: thr = 17'd130051;
            2: thr = 17'd130050;
            3: thr = 17'd2601;
            4: thr = CSR_DATA_W'($urandom_range(0, 6000));
            default: thr = CSR_DATA_W'($urandom_range(0, 130051));
         endcase
         frames = $urandom_range(1, 3);
         long_hold = (phase_no == 2 || phase_no == 9);
         if (long_hold) begin
            wdata = 17'd3;
            hdata = 17'd3;
            frames = 5;
         end
         run_phase(wdata, hdata, thr, frames, long_hold || $urandom_range(0, 3) == 0, long_hold);
         phase_no++;
      end

      for (int i = 0; i < 20000 && stats_due.size() != 0; i++) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (stats_due.size() != 0)
         report_mismatch("results never delivered", 0, stats_due.size());

      $display("Covered %0d pixels and %0d checked frame results over %0d register writes,",
               pixels_sent, results_checked, csr_writes);
      $display("frames from 3x3 to 6x5 with clamped sizes, thresholds 0 to 130051, long stalls.");
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin : watchdog
      #3_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
